FILE: hdl/tmfl_pkg.sv
// Shared constants and types for the trimmed-mean fill-level estimator.
package tmfl_pkg;

   // Default values of the top-level parameters.
   localparam int SAMPLES_DEF   = 8;
   localparam int TRIM_DEF      = 2;
   localparam int DIST_BITS_DEF = 16;

   // Fixed field widths of the ports.
   localparam int DIST_W = 16;
   localparam int MEAN_W = 16;
   localparam int FILL_W = 17;
   localparam int CSR_W  = 16;

   // Q.15 scaling of the fill level.
   localparam int                Q15_SHIFT = 15;
   localparam logic [FILL_W-1:0] Q15_ONE   = 17'd32768;

   // Bin height after reset.
   localparam logic [CSR_W-1:0] BIN_HEIGHT_RST = 16'd1000;

   // Control that every cell of the sorted row receives.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: hdl/tmfl_cell.sv
// One cell of the sorted sample row: insertion in place and shifting towards cell zero.
module tmfl_cell #(
   parameter int DIST_BITS = tmfl_pkg::DIST_BITS_DEF
) (
   input  logic                    clock,
   input  tmfl_pkg::cell_ctrl_type ctrl,
   input  logic [DIST_BITS-1:0]    din,
   input  logic [DIST_BITS-1:0]    prev_val,
   input  logic                    prev_gt,
   input  logic [DIST_BITS-1:0]    next_val,
   input  logic                    occupied,
   input  logic                    at_end,
   output logic [DIST_BITS-1:0]    val,
   output logic                    gt
);

   logic [DIST_BITS-1:0] val_ff;
   logic [DIST_BITS-1:0] val_in;

   // This cell holds a value larger than the incoming item.
   assign gt  = val_ff > din;
   assign val = val_ff;

   // Larger entries move up by one; the item lands above the last smaller or equal entry.
   always_comb begin
      val_in = val_ff;
      if (ctrl.insert) begin
         if ((occupied && gt) || at_end) begin
            val_in = prev_gt ? prev_val : din;
         end
      end else if (ctrl.shift) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

FILE: hdl/tmfl_div.sv
// Restoring serial divider, one quotient bit per cycle.
module tmfl_div #(
   parameter int NUM_W = 31,
   parameter int DEN_W = tmfl_pkg::CSR_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // One step: bring down the next dividend bit and subtract where it fits.
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: hdl/trimmed_mean_fill_level_core.sv
// Top level of the trimmed-mean fill-level estimator: sorted cell row, sum, mean and ratio.
// Each item is inserted into the sorted row as it is taken, so items of a group are taken back to back.
// After the last item of a group the input stalls through a summing shift of the row, one
// reciprocal multiply for the mean and one pass of the bit-serial divider; the result is
// valid as the stall ends. A zero bin height skips the divider; a waiting result holds the row too.
// Synchronous reset empties the group, clears the result valid and sets bin height to 1000.
module trimmed_mean_fill_level_core #(
   parameter int SAMPLES   = tmfl_pkg::SAMPLES_DEF,
   parameter int TRIM      = tmfl_pkg::TRIM_DEF,
   parameter int DIST_BITS = tmfl_pkg::DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tmfl_pkg::DIST_W-1:0]         req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tmfl_pkg::FILL_W-1:0]  rsp_fill_level,
   output logic [tmfl_pkg::MEAN_W-1:0]         rsp_mean_distance,
   output logic                                rsp_clipped,
   input  logic                                csr_we,
   input  logic [tmfl_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int TRIM_EFF = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
   localparam int KEEP     = SAMPLES - 2 * TRIM_EFF;
   localparam int CNT_W    = $clog2(SAMPLES);
   localparam int SUM_W    = DIST_BITS + $clog2(SAMPLES + 1);
   localparam int DW       = (DIST_BITS > tmfl_pkg::CSR_W) ? DIST_BITS : tmfl_pkg::CSR_W;
   localparam int NUM_W    = DW + tmfl_pkg::Q15_SHIFT;
   localparam int FW       = tmfl_pkg::FILL_W;

   // Reciprocal of the kept count: exact truncating division for any sum below 2**SUM_W.
   localparam int              RECIP_L = $clog2(KEEP);
   localparam int              RECIP_S = SUM_W + RECIP_L;
   localparam int              RECIP_W = SUM_W + 1;
   localparam int              PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_S) + 64'(KEEP) - 64'd1) / 64'(KEEP);

   typedef enum logic [2:0] {
      S_FILL, S_SUM, S_MEAN, S_RATIO_GO, S_RATIO_WAIT, S_EMIT
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        shift_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [DIST_BITS-1:0]    mean_ff;
   logic [tmfl_pkg::CSR_W-1:0] bin_height_ff;
   logic                    neg_ff;
   logic signed [FW-1:0]    fill_ff;
   logic                    clip_ff;
   logic                    rsp_valid_ff;
   logic signed [FW-1:0]    rsp_fill_ff;
   logic [tmfl_pkg::MEAN_W-1:0] rsp_mean_ff;
   logic                    rsp_clip_ff;

   logic                    req_accept;
   logic [DIST_BITS-1:0]    din;
   tmfl_pkg::cell_ctrl_type ctrl;
   logic [DIST_BITS-1:0]    cell_val [SAMPLES];
   logic                    cell_gt  [SAMPLES];

   logic [PROD_W-1:0]       mean_prod;

   logic                    div_start;
   logic [NUM_W-1:0]        div_numer;
   logic [tmfl_pkg::CSR_W-1:0] div_denom;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quot;

   logic [DW-1:0]           mean_ext;
   logic [DW-1:0]           bh_ext;
   logic                    mean_above;
   logic [DW-1:0]           dist_diff;
   logic                    quot_big;
   logic [FW-1:0]           quot_low;
   logic                    out_free;

   // Input handshake: items are taken only while the group is filling.
   assign req_stall  = (state_ff != S_FILL);
   assign req_accept = req_valid && !req_stall;
   assign din        = DIST_BITS'(req_distance);

   assign ctrl.insert = req_accept;
   assign ctrl.shift  = (state_ff == S_SUM);

   // Row of sorting cells; cell zero holds the smallest sample.
   for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
      logic [DIST_BITS-1:0] prev_val;
      logic                 prev_gt;
      logic [DIST_BITS-1:0] next_val;

      if (i == 0) begin : g_first
         assign prev_val = '0;
         assign prev_gt  = 1'b0;
      end else begin : g_mid
         assign prev_val = cell_val[i-1];
         assign prev_gt  = cell_gt[i-1];
      end

      if (i == SAMPLES - 1) begin : g_last
         assign next_val = '0;
      end else begin : g_body
         assign next_val = cell_val[i+1];
      end

      tmfl_cell #(
         .DIST_BITS(DIST_BITS)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .din      (din),
         .prev_val (prev_val),
         .prev_gt  (prev_gt),
         .next_val (next_val),
         .occupied (count_ff > CNT_W'(i)),
         .at_end   (count_ff == CNT_W'(i)),
         .val      (cell_val[i]),
         .gt       (cell_gt[i])
      );
   end

   // Mean of the kept samples: the sum times the scaled reciprocal of the kept count.
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(RECIP_W'(RECIP_M));

   // Divider for the distance gap by bin height.
   assign mean_ext   = DW'(mean_ff);
   assign bh_ext     = DW'(bin_height_ff);
   assign mean_above = mean_ext > bh_ext;
   assign dist_diff  = mean_above ? (mean_ext - bh_ext) : (bh_ext - mean_ext);

   assign div_start = (state_ff == S_RATIO_GO);
   assign div_numer = NUM_W'(dist_diff) << tmfl_pkg::Q15_SHIFT;
   assign div_denom = bin_height_ff;

   tmfl_div #(
      .NUM_W(NUM_W),
      .DEN_W(tmfl_pkg::CSR_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Ratio magnitude above one saturates when the mean lies beyond the bin bottom.
   assign quot_big = div_quot > NUM_W'(tmfl_pkg::Q15_ONE);
   assign quot_low = div_quot[FW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         count_ff      <= '0;
         shift_ff      <= '0;
         bin_height_ff <= tmfl_pkg::BIN_HEIGHT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            bin_height_ff <= csr_wdata;
         end
         // The result valid rises when a new result is handed over and falls once it is taken.
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_FILL: begin
               if (req_accept) begin
                  if (count_ff == CNT_W'(SAMPLES - 1)) begin
                     count_ff <= '0;
                     shift_ff <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_SUM;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_SUM: begin
               // Cell zero streams out the row in ascending order; the middle part is summed.
               if (shift_ff >= CNT_W'(TRIM_EFF) && shift_ff < CNT_W'(SAMPLES - TRIM_EFF)) begin
                  sum_ff <= sum_ff + SUM_W'(cell_val[0]);
               end
               shift_ff <= shift_ff + 1'b1;
               if (shift_ff == CNT_W'(SAMPLES - 1)) begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN: begin
               mean_ff <= mean_prod[RECIP_S +: DIST_BITS];
               if (bin_height_ff == '0) begin
                  fill_ff  <= -$signed(tmfl_pkg::Q15_ONE);
                  clip_ff  <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_RATIO_GO;
               end
            end
            S_RATIO_GO: begin
               neg_ff   <= mean_above;
               state_ff <= S_RATIO_WAIT;
            end
            S_RATIO_WAIT: begin
               if (div_done) begin
                  if (!neg_ff) begin
                     fill_ff <= $signed(quot_low);
                     clip_ff <= 1'b0;
                  end else if (quot_big) begin
                     fill_ff <= -$signed(tmfl_pkg::Q15_ONE);
                     clip_ff <= 1'b1;
                  end else begin
                     fill_ff <= $signed(FW'(0) - quot_low);
                     clip_ff <= 1'b0;
                  end
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               // The output register loads when the result is handed over.
               if (out_free) begin
                  rsp_fill_ff <= fill_ff;
                  rsp_mean_ff <= tmfl_pkg::MEAN_W'(mean_ff);
                  rsp_clip_ff <= clip_ff;
                  state_ff    <= S_FILL;
               end
            end
            default: begin
               state_ff <= S_FILL;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fill_level    = rsp_fill_ff;
   assign rsp_mean_distance = rsp_mean_ff;
   assign rsp_clipped       = rsp_clip_ff;

endmodule
